@@ src/assert_macros.svh @@
// Assertion helpers: clock clk, reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every edge out of reset.
`define DCMO_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("dcmo check failed");

// Same-cycle implication.
`define DCMO_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dcmo implication failed");

// Next-cycle implication.
`define DCMO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dcmo next-cycle check failed");

`endif

@@ src/dcmo_pkg.sv @@
package dcmo_pkg;

	localparam int MAX_GOALS  = 31;
	localparam int EXP_TERMS  = 17;
	localparam int SQ_ROUNDS  = 3;
	localparam int IDX_W      = $clog2(MAX_GOALS);
	localparam int CNT_W      = $clog2((MAX_GOALS > EXP_TERMS + 1) ? MAX_GOALS : EXP_TERMS + 1);
	localparam int P_W        = 32;
	localparam int S_W        = 34;
	localparam int ACC_W      = 40;
	localparam int PROD_W     = 64;
	localparam int DIVD_W     = 36;
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYC    = DIVD_W / DIV_BITS;
	localparam int STEP_W     = $clog2(DIV_CYC + 1);
	localparam int PROB_W     = 17;
	localparam int PROB_ONE   = 65536;
	localparam int Q16_HALF   = 8192;
	localparam int IN_W       = 48;
	localparam int OUT_W      = 104;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [P_W-1:0]           p_t;
	typedef logic signed [S_W-1:0]    s_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [DIVD_W-1:0]        dvd_t;
	typedef logic [STEP_W-1:0]        step_t;
	typedef logic [PROB_W-1:0]        prob_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP_INIT,
		ST_EXP_MUL,
		ST_EXP_DIVS,
		ST_EXP_DIVW,
		ST_SQ_INIT,
		ST_SQ_MUL,
		ST_SQ_UPD,
		ST_P0,
		ST_P_MUL,
		ST_P_DIVS,
		ST_P_DIVW,
		ST_T_MUL,
		ST_T_P11,
		ST_T_MUL2,
		ST_T_D
	} state_t;

	typedef enum logic [1:0] {
		PH_CALC,
		PH_GRID,
		PH_DRAIN,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		MUL_EXP,
		MUL_SQ,
		MUL_POIS,
		MUL_GRID,
		MUL_TAU
	} mul_src_t;

	typedef struct packed {
		logic     load;
		logic     exp_init;
		logic     mul_en;
		mul_src_t mul_src;
		logic     div_exp;
		logic     div_pois;
		logic     exp_upd;
		logic     u_init;
		logic     sq_upd;
		logic     p0_wr;
		logic     p_wr;
		logic     p11_upd;
		logic     d_upd;
		logic     grid_vld;
		logic     out_wr;
		logic     side;
		cnt_t     cnt;
		idx_t     j;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_full;
	} status_t;

endpackage

@@ src/dcmo_div.sv @@
module dcmo_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dcmo_pkg::dvd_t dividend,
	input  dcmo_pkg::cnt_t divisor,
	output dcmo_pkg::dvd_t quot,
	output logic           busy,
	output logic           done
);

	dcmo_pkg::dvd_t  quo_q;
	dcmo_pkg::cnt_t  rem_q;
	dcmo_pkg::cnt_t  dvs_q;
	dcmo_pkg::step_t step_q;
	logic            done_q;
	dcmo_pkg::dvd_t  quo_n;
	dcmo_pkg::cnt_t  rem_n;

	always_comb begin
		logic [dcmo_pkg::CNT_W:0] r1;
		quo_n = quo_q;
		rem_n = rem_q;
		for (int b = 0; b < dcmo_pkg::DIV_BITS; b++) begin
			r1    = {rem_n, quo_n[dcmo_pkg::DIVD_W-1]};
			quo_n = {quo_n[dcmo_pkg::DIVD_W-2:0], 1'b0};
			if (r1 >= {1'b0, dvs_q}) begin
				r1       = r1 - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end
			rem_n = r1[dcmo_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == dcmo_pkg::step_t'(1));
			if (start) begin
				step_q <= dcmo_pkg::step_t'(dcmo_pkg::DIV_CYC);
			end else if (step_q != '0) begin
				step_q <= step_q - dcmo_pkg::step_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step_q != '0) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign quot = quo_q;
	assign busy = (step_q != '0);
	assign done = done_q;

endmodule

@@ src/dcmo_datapath.sv @@
module dcmo_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dcmo_pkg::IN_W-1:0]     in_data,
	input  dcmo_pkg::cmd_t                cmd,
	output dcmo_pkg::status_t             status,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [dcmo_pkg::OUT_W-1:0]    m_axis_tdata
);

	logic [14:0]     mu_h_q, mu_a_q;
	logic [15:0]     rmag_q;
	logic            neg_q;
	dcmo_pkg::p_t    t_q, u_q, p11_q;
	dcmo_pkg::s_t    s_q;
	dcmo_pkg::p_t    h_q [dcmo_pkg::MAX_GOALS];
	dcmo_pkg::p_t    a_q [dcmo_pkg::MAX_GOALS];
	dcmo_pkg::prod_t prod_q;
	dcmo_pkg::acc_t  d_q;
	dcmo_pkg::idx_t  gi_s1, gj_s1;
	logic            gv_s1;
	dcmo_pkg::acc_t  acc_h_q, acc_d_q, acc_a_q, acc_b_q, acc_hs_q, acc_as_q;
	dcmo_pkg::prob_t o_h_q, o_d_q, o_a_q, o_b_q, o_hs_q, o_as_q;
	logic            m_tvalid_q;

	logic [14:0]     mu_sel;
	dcmo_pkg::idx_t  h_addr, a_addr, base;
	dcmo_pkg::p_t    h_rd, a_rd, pois_rd;
	dcmo_pkg::p_t    opa, opb;
	dcmo_pkg::prod_t exp_num, pois_num, rnd30, sq_num, tau_num;
	dcmo_pkg::dvd_t  div_in, quot;
	dcmo_pkg::p_t    qv;
	logic            div_busy, div_done;
	dcmo_pkg::acc_t  grid_cell, cell_adj;
	logic [15:0]     r_raw;

	function automatic dcmo_pkg::prob_t q16(input dcmo_pkg::acc_t v);
		dcmo_pkg::acc_t r;
		begin
			r = (v + dcmo_pkg::acc_t'(dcmo_pkg::Q16_HALF)) >>> 14;
			if (v <= 0)
				q16 = '0;
			else if (r > dcmo_pkg::acc_t'(dcmo_pkg::PROB_ONE))
				q16 = dcmo_pkg::prob_t'(dcmo_pkg::PROB_ONE);
			else
				q16 = r[dcmo_pkg::PROB_W-1:0];
		end
	endfunction

	assign mu_sel  = cmd.side ? mu_a_q : mu_h_q;
	assign base    = cmd.cnt[dcmo_pkg::IDX_W-1:0];
	assign h_addr  = (cmd.mul_src == dcmo_pkg::MUL_POIS) ? base - dcmo_pkg::idx_t'(1) : base;
	assign a_addr  = (cmd.mul_src == dcmo_pkg::MUL_POIS) ? base - dcmo_pkg::idx_t'(1) : cmd.j;
	assign h_rd    = h_q[h_addr];
	assign a_rd    = a_q[a_addr];
	assign pois_rd = cmd.side ? a_rd : h_rd;

	always_comb begin
		opa = '0;
		opb = '0;
		unique case (cmd.mul_src)
			dcmo_pkg::MUL_EXP: begin
				opa = t_q;
				opb = dcmo_pkg::p_t'(mu_sel);
			end
			dcmo_pkg::MUL_SQ: begin
				opa = u_q;
				opb = u_q;
			end
			dcmo_pkg::MUL_POIS: begin
				opa = pois_rd;
				opb = dcmo_pkg::p_t'(mu_sel);
			end
			dcmo_pkg::MUL_GRID: begin
				opa = h_rd;
				opb = a_rd;
			end
			dcmo_pkg::MUL_TAU: begin
				opa = dcmo_pkg::p_t'(rmag_q);
				opb = p11_q;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign exp_num  = prod_q + (dcmo_pkg::prod_t'(cmd.cnt) << 14);
	assign pois_num = prod_q + (dcmo_pkg::prod_t'(cmd.cnt) << 11);
	assign rnd30    = prod_q + (dcmo_pkg::prod_t'(1) << 29);
	assign sq_num   = rnd30;
	assign tau_num  = prod_q + (dcmo_pkg::prod_t'(1) << 14);
	assign div_in   = cmd.div_pois ? pois_num[12 +: dcmo_pkg::DIVD_W]
	                               : exp_num[15 +: dcmo_pkg::DIVD_W];
	assign qv       = quot[dcmo_pkg::P_W-1:0];
	assign r_raw    = in_data[45:30];

	dcmo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_exp | cmd.div_pois),
		.dividend (div_in),
		.divisor  (cmd.cnt),
		.quot     (quot),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_comb begin
		grid_cell = dcmo_pkg::acc_t'(rnd30[63:30]);
		cell_adj  = grid_cell;
		if (gi_s1 < dcmo_pkg::idx_t'(2) && gj_s1 < dcmo_pkg::idx_t'(2)) begin
			if (gi_s1 == gj_s1)
				cell_adj = grid_cell - d_q;
			else
				cell_adj = grid_cell + d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mu_h_q <= in_data[14:0];
			mu_a_q <= in_data[29:15];
			neg_q  <= r_raw[15];
			rmag_q <= r_raw[15] ? (16'd0 - r_raw) : r_raw;
		end
		if (cmd.mul_en)
			prod_q <= dcmo_pkg::prod_t'(opa) * dcmo_pkg::prod_t'(opb);
		if (cmd.exp_init) begin
			t_q <= dcmo_pkg::p_t'(1) << 30;
			s_q <= dcmo_pkg::s_t'(1) <<< 30;
		end else if (cmd.exp_upd) begin
			t_q <= qv;
			s_q <= cmd.cnt[0] ? s_q - dcmo_pkg::s_t'(qv) : s_q + dcmo_pkg::s_t'(qv);
		end
		if (cmd.u_init)
			u_q <= (s_q > 0) ? dcmo_pkg::p_t'(s_q) : '0;
		else if (cmd.sq_upd)
			u_q <= sq_num[30 +: dcmo_pkg::P_W];
		if (cmd.p0_wr) begin
			if (cmd.side)
				a_q[0] <= u_q;
			else
				h_q[0] <= u_q;
		end
		if (cmd.p_wr) begin
			if (cmd.side)
				a_q[base] <= qv;
			else
				h_q[base] <= qv;
		end
		if (cmd.p11_upd)
			p11_q <= rnd30[30 +: dcmo_pkg::P_W];
		if (cmd.d_upd) begin
			d_q <= neg_q ? -dcmo_pkg::acc_t'(tau_num[15 +: dcmo_pkg::P_W])
			             : dcmo_pkg::acc_t'(tau_num[15 +: dcmo_pkg::P_W]);
			acc_h_q  <= '0;
			acc_d_q  <= '0;
			acc_a_q  <= '0;
			acc_b_q  <= '0;
			acc_hs_q <= '0;
			acc_as_q <= '0;
		end else if (gv_s1) begin
			if (gi_s1 > gj_s1)
				acc_h_q <= acc_h_q + cell_adj;
			else if (gi_s1 == gj_s1)
				acc_d_q <= acc_d_q + cell_adj;
			else
				acc_a_q <= acc_a_q + cell_adj;
			if (gi_s1 != '0)
				acc_hs_q <= acc_hs_q + cell_adj;
			if (gj_s1 != '0)
				acc_as_q <= acc_as_q + cell_adj;
			if (gi_s1 != '0 && gj_s1 != '0)
				acc_b_q <= acc_b_q + cell_adj;
		end
		gi_s1 <= base;
		gj_s1 <= cmd.j;
		if (cmd.out_wr) begin
			o_h_q  <= q16(acc_h_q);
			o_d_q  <= q16(acc_d_q);
			o_a_q  <= q16(acc_a_q);
			o_b_q  <= q16(acc_b_q);
			o_hs_q <= q16(acc_hs_q);
			o_as_q <= q16(acc_as_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			gv_s1 <= cmd.grid_vld;
			if (cmd.out_wr)
				m_tvalid_q <= 1'b1;
			else if (m_axis_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.out_full = m_tvalid_q & ~m_axis_tready;
	assign m_axis_tvalid   = m_tvalid_q;
	assign m_axis_tdata    = {2'b00, o_as_q, o_hs_q, o_b_q, o_a_q, o_d_q, o_h_q};

endmodule

@@ src/dcmo_ctrl.sv @@
`include "assert_macros.svh"

module dcmo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  dcmo_pkg::status_t status,
	output dcmo_pkg::cmd_t    cmd
);

	dcmo_pkg::state_t state_q, state_n;
	dcmo_pkg::phase_t phase_q, phase_n;
	dcmo_pkg::cnt_t   cnt_q, cnt_n;
	dcmo_pkg::idx_t   j_q, j_n;
	logic             side_q, side_n;
	logic             home_done;

	localparam dcmo_pkg::cnt_t LAST_I = dcmo_pkg::cnt_t'(dcmo_pkg::MAX_GOALS - 1);
	localparam dcmo_pkg::idx_t LAST_J = dcmo_pkg::idx_t'(dcmo_pkg::MAX_GOALS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcmo_pkg::ST_IDLE;
			phase_q <= dcmo_pkg::PH_CALC;
			cnt_q   <= '0;
			j_q     <= '0;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			j_q     <= j_n;
			side_q  <= side_n;
		end
	end

	always_comb begin
		state_n       = state_q;
		phase_n       = phase_q;
		cnt_n         = cnt_q;
		j_n           = j_q;
		side_n        = side_q;
		s_axis_tready = 1'b0;
		cmd           = '0;
		cmd.mul_src   = dcmo_pkg::MUL_GRID;
		cmd.side      = side_q;
		cmd.cnt       = cnt_q;
		cmd.j         = j_q;
		unique case (phase_q)
			dcmo_pkg::PH_GRID: begin
				cmd.mul_en   = 1'b1;
				cmd.grid_vld = 1'b1;
				if (j_q == LAST_J) begin
					j_n = '0;
					if (cnt_q == LAST_I)
						phase_n = dcmo_pkg::PH_DRAIN;
					else
						cnt_n = cnt_q + dcmo_pkg::cnt_t'(1);
				end else begin
					j_n = j_q + dcmo_pkg::idx_t'(1);
				end
			end
			dcmo_pkg::PH_DRAIN: phase_n = dcmo_pkg::PH_DONE;
			dcmo_pkg::PH_DONE: begin
				if (!status.out_full) begin
					cmd.out_wr = 1'b1;
					phase_n    = dcmo_pkg::PH_CALC;
					state_n    = dcmo_pkg::ST_IDLE;
				end
			end
			default: begin
				unique case (state_q)
					dcmo_pkg::ST_IDLE: begin
						s_axis_tready = 1'b1;
						if (s_axis_tvalid) begin
							cmd.load = 1'b1;
							side_n   = 1'b0;
							state_n  = dcmo_pkg::ST_EXP_INIT;
						end
					end
					dcmo_pkg::ST_EXP_INIT: begin
						cmd.exp_init = 1'b1;
						cnt_n        = dcmo_pkg::cnt_t'(1);
						state_n      = dcmo_pkg::ST_EXP_MUL;
					end
					dcmo_pkg::ST_EXP_MUL: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_src = dcmo_pkg::MUL_EXP;
						state_n     = dcmo_pkg::ST_EXP_DIVS;
					end
					dcmo_pkg::ST_EXP_DIVS: begin
						cmd.div_exp = 1'b1;
						state_n     = dcmo_pkg::ST_EXP_DIVW;
					end
					dcmo_pkg::ST_EXP_DIVW: begin
						if (status.div_done) begin
							cmd.exp_upd = 1'b1;
							if (cnt_q == dcmo_pkg::cnt_t'(dcmo_pkg::EXP_TERMS)) begin
								state_n = dcmo_pkg::ST_SQ_INIT;
							end else begin
								cnt_n   = cnt_q + dcmo_pkg::cnt_t'(1);
								state_n = dcmo_pkg::ST_EXP_MUL;
							end
						end
					end
					dcmo_pkg::ST_SQ_INIT: begin
						cmd.u_init = 1'b1;
						cnt_n      = '0;
						state_n    = dcmo_pkg::ST_SQ_MUL;
					end
					dcmo_pkg::ST_SQ_MUL: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_src = dcmo_pkg::MUL_SQ;
						state_n     = dcmo_pkg::ST_SQ_UPD;
					end
					dcmo_pkg::ST_SQ_UPD: begin
						cmd.sq_upd = 1'b1;
						if (cnt_q == dcmo_pkg::cnt_t'(dcmo_pkg::SQ_ROUNDS - 1)) begin
							state_n = dcmo_pkg::ST_P0;
						end else begin
							cnt_n   = cnt_q + dcmo_pkg::cnt_t'(1);
							state_n = dcmo_pkg::ST_SQ_MUL;
						end
					end
					dcmo_pkg::ST_P0: begin
						cmd.p0_wr = 1'b1;
						cnt_n     = dcmo_pkg::cnt_t'(1);
						state_n   = dcmo_pkg::ST_P_MUL;
					end
					dcmo_pkg::ST_P_MUL: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_src = dcmo_pkg::MUL_POIS;
						state_n     = dcmo_pkg::ST_P_DIVS;
					end
					dcmo_pkg::ST_P_DIVS: begin
						cmd.div_pois = 1'b1;
						state_n      = dcmo_pkg::ST_P_DIVW;
					end
					dcmo_pkg::ST_P_DIVW: begin
						if (status.div_done) begin
							cmd.p_wr = 1'b1;
							if (cnt_q == LAST_I) begin
								if (side_q) begin
									cnt_n   = dcmo_pkg::cnt_t'(1);
									j_n     = dcmo_pkg::idx_t'(1);
									state_n = dcmo_pkg::ST_T_MUL;
								end else begin
									side_n  = 1'b1;
									state_n = dcmo_pkg::ST_EXP_INIT;
								end
							end else begin
								cnt_n   = cnt_q + dcmo_pkg::cnt_t'(1);
								state_n = dcmo_pkg::ST_P_MUL;
							end
						end
					end
					dcmo_pkg::ST_T_MUL: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_src = dcmo_pkg::MUL_GRID;
						state_n     = dcmo_pkg::ST_T_P11;
					end
					dcmo_pkg::ST_T_P11: begin
						cmd.p11_upd = 1'b1;
						state_n     = dcmo_pkg::ST_T_MUL2;
					end
					dcmo_pkg::ST_T_MUL2: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_src = dcmo_pkg::MUL_TAU;
						state_n     = dcmo_pkg::ST_T_D;
					end
					dcmo_pkg::ST_T_D: begin
						cmd.d_upd = 1'b1;
						cnt_n     = '0;
						j_n       = '0;
						phase_n   = dcmo_pkg::PH_GRID;
					end
					default: state_n = dcmo_pkg::ST_IDLE;
				endcase
			end
		endcase
	end

	assign home_done = state_q == dcmo_pkg::ST_P_DIVW && status.div_done && cnt_q == LAST_I
		&& !side_q && phase_q == dcmo_pkg::PH_CALC;

	`DCMO_ASSERT_IMPL(a_div_start_idle, cmd.div_exp || cmd.div_pois, !status.div_busy)
	`DCMO_ASSERT_NEXT(a_side_switch, home_done, state_q == dcmo_pkg::ST_EXP_INIT && side_q)
	`DCMO_ASSERT_IMPL(a_grid_range, phase_q == dcmo_pkg::PH_GRID, cnt_q <= LAST_I && j_q <= LAST_J)
	`DCMO_ASSERT_IMPL(a_ready_idle, s_axis_tready, phase_q == dcmo_pkg::PH_CALC && !status.div_busy)

endmodule

@@ src/dixon_coles_match_outcome_top.sv @@
// One item in flight at a time. Run time is set by 94 Poisson/exp terms on the
//   4-bit-per-cycle divider and by the shared 32x32 multiplier walking the 31x31 grid.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset: arst_n asynchronous, active low; clears the controller and output valid.
// No state is kept between items.
module dixon_coles_match_outcome_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // mu_home[14:0], mu_away[29:15], rho_adjust[45:30]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata   // home_win, draw, away_win, both_score,
	                                    // home_scores, away_scores: 17 bits each
);

	dcmo_pkg::cmd_t    cmd;
	dcmo_pkg::status_t status;

	dcmo_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	dcmo_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_data       (s_axis_tdata),
		.cmd           (cmd),
		.status        (status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
